// ===== hdl/fat_long_name_assembler_macros.svh =====
// Assertion macros for the long name assembler.
// Define NO_ASSERTIONS to compile them out.
`ifndef FAT_LONG_NAME_ASSEMBLER_MACROS_SVH
`define FAT_LONG_NAME_ASSEMBLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked every clock outside reset
`define FLNA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("flna: property failed");
// pre in one cycle implies post in the next
`define FLNA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("flna: sequence failed");
`else
`define FLNA_ASSERT(lbl, prop)
`define FLNA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== hdl/flna_pkg.sv =====
package flna_pkg;

	localparam logic       KIND_READ     = 1'b1;
	localparam logic [4:0] LAST_BYTE     = 5'd31;
	// checksum sweep: address 0..14, read data is registered
	localparam logic [3:0] CK_LAST       = 4'd14;
	localparam logic [3:0] CK_BYTES      = 4'd11;
	localparam logic [3:0] IDX_ORD       = 4'd0;
	localparam logic [3:0] IDX_ATTR      = 4'd11;
	localparam logic [3:0] IDX_CKS       = 4'd13;
	localparam logic [3:0] LFN_ATTR      = 4'hF;
	localparam int         LAST_FLAG_BIT = 6;
	localparam logic [15:0] UCS_SKIP     = 16'hFFFF;
	localparam logic [7:0] CHAR_SUB      = 8'h3F;
	localparam logic [3:0] LAST_CHAR     = 4'd12;

	typedef enum logic [1:0] {
		ST_LONG_OK,
		ST_LONG_REJ,
		ST_SHORT_MATCH,
		ST_SHORT_NONE
	} status_t;

	typedef enum logic [3:0] {
		S_CLR_RST,
		S_IDLE,
		S_CK,
		S_DEC,
		S_CLR_LONG,
		S_CH_LO,
		S_CH_HI,
		S_CH_WR,
		S_RD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic ck_step;
		logic dec;
		logic clr_wr;
		logic ch_lo;
		logic ch_hi;
		logic ch_wr;
		logic rd_cap;
		logic fin_load;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic in_kind;
		logic in_last;
		logic ck_last;
		logic is_long;
		logic ord_zero;
		logic last_flag;
		logic reject;
		logic clr_done;
		logic ch_end;
		logic out_free;
	} flags_t;

	// byte offset of the low half of UCS-2 character k in a long-name entry
	function automatic logic [4:0] char_off(input logic [3:0] k);
		logic [4:0] off;
		unique case (k)
			4'd0:    off = 5'd1;
			4'd1:    off = 5'd3;
			4'd2:    off = 5'd5;
			4'd3:    off = 5'd7;
			4'd4:    off = 5'd9;
			4'd5:    off = 5'd14;
			4'd6:    off = 5'd16;
			4'd7:    off = 5'd18;
			4'd8:    off = 5'd20;
			4'd9:    off = 5'd22;
			4'd10:   off = 5'd24;
			4'd11:   off = 5'd28;
			4'd12:   off = 5'd30;
			default: off = 5'd0;
		endcase
		return off;
	endfunction

endpackage

// ===== hdl/flna_ram.sv =====
module flna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/flna_alu.sv =====
module flna_alu (
	input  logic [7:0]  sum,
	input  logic [7:0]  data_in,
	input  logic [15:0] ucs,
	output logic [7:0]  sum_next,
	output logic [7:0]  ch,
	output logic        ch_keep
);

	// 8.3 checksum step: rotate right by one, then add
	assign sum_next = {sum[0], sum[7:1]} + data_in;

	// zero and Latin-1 pass through, anything wider maps to '?'
	assign ch      = (ucs[15:8] == 8'd0) ? ucs[7:0] : flna_pkg::CHAR_SUB;
	assign ch_keep = (ucs != flna_pkg::UCS_SKIP);

endmodule

// ===== hdl/flna_fsm.sv =====
module flna_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  flna_pkg::flags_t flags,
	output flna_pkg::ctrl_t  ctrl
);

	flna_pkg::state_t state_q;
	flna_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flna_pkg::S_CLR_RST;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			flna_pkg::S_CLR_RST: begin
				if (flags.clr_done) state_d = flna_pkg::S_IDLE;
			end
			flna_pkg::S_IDLE: begin
				if (flags.in_acc) begin
					if (flags.in_kind) state_d = flna_pkg::S_RD;
					else if (flags.in_last) state_d = flna_pkg::S_CK;
				end
			end
			flna_pkg::S_CK: begin
				if (flags.ck_last) state_d = flna_pkg::S_DEC;
			end
			flna_pkg::S_DEC: begin
				if (!flags.is_long || flags.ord_zero) state_d = flna_pkg::S_FIN;
				else if (flags.last_flag) state_d = flna_pkg::S_CLR_LONG;
				else if (flags.reject) state_d = flna_pkg::S_FIN;
				else state_d = flna_pkg::S_CH_LO;
			end
			flna_pkg::S_CLR_LONG: begin
				if (flags.clr_done) state_d = flna_pkg::S_CH_LO;
			end
			flna_pkg::S_CH_LO: state_d = flna_pkg::S_CH_HI;
			flna_pkg::S_CH_HI: state_d = flna_pkg::S_CH_WR;
			flna_pkg::S_CH_WR: begin
				state_d = flags.ch_end ? flna_pkg::S_FIN : flna_pkg::S_CH_LO;
			end
			flna_pkg::S_RD: state_d = flna_pkg::S_FIN;
			flna_pkg::S_FIN: begin
				if (flags.out_free) state_d = flna_pkg::S_IDLE;
			end
			default: state_d = flna_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			flna_pkg::S_CLR_RST:  ctrl.clr_wr = 1'b1;
			flna_pkg::S_IDLE:     ctrl.in_ready = 1'b1;
			flna_pkg::S_CK:       ctrl.ck_step = 1'b1;
			flna_pkg::S_DEC:      ctrl.dec = 1'b1;
			flna_pkg::S_CLR_LONG: ctrl.clr_wr = 1'b1;
			flna_pkg::S_CH_LO:    ctrl.ch_lo = 1'b1;
			flna_pkg::S_CH_HI:    ctrl.ch_hi = 1'b1;
			flna_pkg::S_CH_WR:    ctrl.ch_wr = 1'b1;
			flna_pkg::S_RD:       ctrl.rd_cap = 1'b1;
			flna_pkg::S_FIN:      ctrl.fin_load = flags.out_free;
			default:              ctrl = '0;
		endcase
	end

endmodule

// ===== hdl/fat_long_name_assembler.sv =====
// Long file name assembler for FAT directory entries.
// Input stream (s_*): one transaction per entry byte or per name read.
//   s_tuser[0] = 0: entry byte; byte_index 31 closes the entry and starts
//   processing. s_tuser[0] = 1: read the name store at name_index.
// Output stream (m_*): one transaction per closed entry and per read.
// Work per input transaction, with s_tready low while it runs:
//   entry byte 0..30: written to the entry buffer, back to back.
//   byte 31: the 11-byte checksum sweep and the decision, then zeroing of
//     the name store when the entry carries the last flag, then a low-half
//     read, high-half read and write per long-name character (up to 13).
//     The single entry-buffer read port serializes these steps.
//   name read: the name store is read, then the result is loaded.
// The result sits in an output register; the sequencer keeps working on the
// next transaction while it waits and stalls only when it has a new result
// while the old one is still held and m_tready is low.
// After reset the name store is zeroed, address 0 to NAME_MAX, with s_tready low.
`include "fat_long_name_assembler_macros.svh"

module fat_long_name_assembler #(
	parameter int NAME_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // entry_byte[7:0], byte_index[12:8], name_index[20:13]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // entry_status[1:0], short_checksum[9:2],
	                              // name_char[17:10], long_name_valid[18], next_order[23:19]
);

	localparam int AW = $clog2(NAME_MAX + 1);
	localparam int PW = (AW > 9) ? AW : 9;
	localparam int IW = (AW > 8) ? AW : 8;

	flna_pkg::ctrl_t  ctrl;
	flna_pkg::flags_t flags;

	logic       in_acc;
	logic       kind;
	logic [7:0] entry_byte;
	logic [4:0] byte_index;
	logic [7:0] name_index;
	logic [IW-1:0] idx_ext;
	logic          in_range;

	logic       ent_we;
	logic [4:0] ent_raddr;
	logic [7:0] ent_rdata;

	logic          nm_we;
	logic [AW-1:0] nm_waddr;
	logic [7:0]    nm_wdata;
	logic [7:0]    nm_rdata;

	logic [3:0]    cnt_q;
	logic [7:0]    sum_q;
	logic [7:0]    b0_q;
	logic [7:0]    attr_q;
	logic [7:0]    b13_q;
	logic [7:0]    lo_q;
	logic [4:0]    exp_q;
	logic [7:0]    saved_q;
	logic          valid_q;
	logic          store0_q;
	logic [AW-1:0] clr_q;
	logic [3:0]    k_q;
	logic [PW-1:0] pos_q;
	logic          rd_ok_q;
	logic [7:0]    char_q;
	flna_pkg::status_t status_q;
	logic          out_valid_q;
	logic [23:0]   out_data_q;

	logic [3:0]    ck_idx;
	logic [7:0]    sum_next;
	logic [15:0]   ucs;
	logic [7:0]    alu_ch;
	logic          ch_keep;
	logic [4:0]    ord;
	logic [4:0]    ord_m1;
	logic [PW-1:0] ord_m1_w;
	logic [PW-1:0] base;
	logic          match;
	logic          long_clear;

	assign entry_byte = s_tdata[7:0];
	assign byte_index = s_tdata[12:8];
	assign name_index = s_tdata[20:13];
	assign kind       = s_tuser[0];
	assign s_tready   = ctrl.in_ready;
	assign in_acc     = s_tvalid && s_tready;
	assign idx_ext    = IW'(name_index);
	assign in_range   = (idx_ext <= IW'(NAME_MAX));

	assign ck_idx   = cnt_q - 4'd1;
	assign ucs      = {ent_rdata, lo_q};
	assign ord      = b0_q[4:0];
	assign ord_m1   = ord - 5'd1;
	assign ord_m1_w = PW'(ord_m1);
	// (ord - 1) * 13
	assign base     = (ord_m1_w << 3) + (ord_m1_w << 2) + ord_m1_w;
	assign match    = valid_q && (exp_q == 5'd0) && (sum_q == saved_q) && store0_q;

	always_comb begin
		flags.in_acc    = in_acc;
		flags.in_kind   = (kind == flna_pkg::KIND_READ);
		flags.in_last   = (byte_index == flna_pkg::LAST_BYTE);
		flags.ck_last   = (cnt_q == flna_pkg::CK_LAST);
		flags.is_long   = (attr_q[3:0] == flna_pkg::LFN_ATTR);
		flags.ord_zero  = (ord == 5'd0);
		flags.last_flag = b0_q[flna_pkg::LAST_FLAG_BIT];
		flags.reject    = !valid_q || (ord != exp_q) || (b13_q != saved_q);
		flags.clr_done  = (clr_q == AW'(NAME_MAX));
		flags.ch_end    = (ucs == 16'd0) || (k_q == flna_pkg::LAST_CHAR);
		flags.out_free  = !out_valid_q || m_tready;
	end

	// long entry that drops the accumulation without a new start
	assign long_clear = flags.is_long &&
		(flags.ord_zero || (!flags.last_flag && flags.reject));

	flna_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	flna_alu u_alu (
		.sum      (sum_q),
		.data_in  (ent_rdata),
		.ucs      (ucs),
		.sum_next (sum_next),
		.ch       (alu_ch),
		.ch_keep  (ch_keep)
	);

	assign ent_we = in_acc && (kind != flna_pkg::KIND_READ);

	always_comb begin
		ent_raddr = 5'd0;
		if (ctrl.ck_step) ent_raddr = {1'b0, cnt_q};
		else if (ctrl.ch_lo) ent_raddr = flna_pkg::char_off(k_q);
		else if (ctrl.ch_hi) ent_raddr = flna_pkg::char_off(k_q) + 5'd1;
	end

	flna_ram #(
		.WIDTH (8),
		.DEPTH (32)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (byte_index),
		.wdata (entry_byte),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_comb begin
		nm_we    = 1'b0;
		nm_waddr = pos_q[AW-1:0];
		nm_wdata = alu_ch;
		if (ctrl.clr_wr) begin
			nm_we    = 1'b1;
			nm_waddr = clr_q;
			nm_wdata = 8'd0;
		end else if (ctrl.dec && long_clear) begin
			nm_we    = 1'b1;
			nm_waddr = '0;
			nm_wdata = 8'd0;
		end else if (ctrl.ch_wr && ch_keep && (pos_q < PW'(NAME_MAX))) begin
			nm_we = 1'b1;
		end
	end

	flna_ram #(
		.WIDTH (8),
		.DEPTH (NAME_MAX + 1)
	) u_name_ram (
		.clk   (clk),
		.we    (nm_we),
		.waddr (nm_waddr),
		.wdata (nm_wdata),
		.raddr (idx_ext[AW-1:0]),
		.rdata (nm_rdata)
	);

	// accumulator and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= '0;
			saved_q     <= '0;
			valid_q     <= 1'b0;
			store0_q    <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clr_wr) begin
				clr_q <= flags.clr_done ? '0 : clr_q + AW'(1);
			end
			if (nm_we && (nm_waddr == '0)) begin
				store0_q <= (nm_wdata != 8'd0);
			end
			if (ctrl.dec && long_clear) begin
				exp_q   <= '0;
				saved_q <= '0;
				valid_q <= 1'b0;
			end else if (ctrl.dec && flags.is_long && flags.last_flag) begin
				exp_q   <= ord;
				saved_q <= b13_q;
				valid_q <= 1'b1;
			end else if (ctrl.ch_wr && flags.ch_end) begin
				exp_q <= ord_m1;
			end
			if (ctrl.fin_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			char_q   <= '0;
			status_q <= flna_pkg::ST_LONG_OK;
			rd_ok_q  <= in_range;
		end
		if (ctrl.ck_step) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q != 4'd0) begin
				if (ck_idx < flna_pkg::CK_BYTES) sum_q <= sum_next;
				if (ck_idx == flna_pkg::IDX_ORD) b0_q <= ent_rdata;
				if (ck_idx == flna_pkg::IDX_ATTR) attr_q <= ent_rdata;
				if (ck_idx == flna_pkg::IDX_CKS) b13_q <= ent_rdata;
			end
		end
		if (ctrl.dec) begin
			k_q   <= '0;
			pos_q <= base;
			if (!flags.is_long) begin
				status_q <= match ? flna_pkg::ST_SHORT_MATCH : flna_pkg::ST_SHORT_NONE;
			end else if (long_clear) begin
				status_q <= flna_pkg::ST_LONG_REJ;
			end
		end
		if (ctrl.ch_hi) begin
			lo_q <= ent_rdata;
		end
		if (ctrl.ch_wr) begin
			if (flags.ch_end) begin
				status_q <= flna_pkg::ST_LONG_OK;
			end else begin
				k_q   <= k_q + 4'd1;
				pos_q <= pos_q + PW'(1);
			end
		end
		if (ctrl.rd_cap) begin
			char_q <= rd_ok_q ? nm_rdata : 8'd0;
		end
		if (ctrl.fin_load) begin
			out_data_q <= {exp_q, valid_q, char_q, sum_q, status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`FLNA_ASSERT_NEXT(a_fin_shows, ctrl.fin_load, m_tvalid)
	`FLNA_ASSERT(a_idle_accum, !valid_q |-> (exp_q == 5'd0 && saved_q == 8'd0))
	`FLNA_ASSERT(a_clr_stall, ctrl.clr_wr |-> !s_tready)
	`FLNA_ASSERT(a_ch_bound, ctrl.ch_wr |-> (k_q <= flna_pkg::LAST_CHAR))
	`FLNA_ASSERT(a_idle_nowr, s_tready |-> !nm_we)

endmodule
